>>> src/imu_fd_pkg.sv
// Shared types and constants for the IMU serial frame deframer.
// Used by imu_fd_parser and imu_frame_deframer; no dependencies.
package imu_fd_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;
    localparam int PAYLOAD_N   = 8;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_PRESS = 8'h56;
    localparam logic [7:0] TYPE_QUAT  = 8'h59;

    localparam logic [2:0] KIND_ACC     = 3'd0;
    localparam logic [2:0] KIND_GYRO    = 3'd1;
    localparam logic [2:0] KIND_ANGLE   = 3'd2;
    localparam logic [2:0] KIND_PRESS   = 3'd3;
    localparam logic [2:0] KIND_QUAT    = 3'd4;
    localparam logic [2:0] KIND_SUMMARY = 3'd5;

    // seen flag bit positions
    localparam int FLAG_ACC   = 0;
    localparam int FLAG_GYRO  = 1;
    localparam int FLAG_PRESS = 2;
    localparam int FLAG_ATT   = 3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] word0;
        logic signed [15:0] word1;
        logic signed [15:0] word2;
        logic signed [15:0] word3;
        logic signed [31:0] pressure;
        logic [7:0]         frame_index;
        logic               set_complete;
    } result_t;

endpackage

>>> src/imu_fd_parser.sv
// Frame parser core: header hunt, type decode, payload capture, burst flags.
// Depends on imu_fd_pkg. Advances one item per cycle when step is high.
module imu_fd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                action,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output imu_fd_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [3:0]  count_reg,  count_next;
    logic [2:0]  fkind_reg,  fkind_next;
    logic [3:0]  seen_reg,   seen_next;
    logic [7:0]  frames_reg, frames_next;
    logic [7:0]  payload_reg [imu_fd_pkg::PAYLOAD_N];
    logic        buf_we;
    logic [3:0]  kind_flag;

    always_comb begin
        kind_flag = '0;
        unique case (fkind_reg)
            imu_fd_pkg::KIND_ACC:   kind_flag[imu_fd_pkg::FLAG_ACC]   = 1'b1;
            imu_fd_pkg::KIND_GYRO:  kind_flag[imu_fd_pkg::FLAG_GYRO]  = 1'b1;
            imu_fd_pkg::KIND_PRESS: kind_flag[imu_fd_pkg::FLAG_PRESS] = 1'b1;
            default:                kind_flag[imu_fd_pkg::FLAG_ATT]   = 1'b1;
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        fkind_next  = fkind_reg;
        seen_next   = seen_reg;
        frames_next = frames_reg;
        buf_we      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        if (action) begin
            // end of burst: report and clear, parser position is kept
            res_valid        = 1'b1;
            res.kind         = imu_fd_pkg::KIND_SUMMARY;
            res.frame_index  = frames_reg;
            res.set_complete = &seen_reg;
            seen_next        = '0;
            frames_next      = '0;
        end else begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == imu_fd_pkg::HDR_BYTE) phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    phase_next = PH_BODY;
                    count_next = '0;
                    unique case (rx_byte)
                        imu_fd_pkg::TYPE_ACC:   fkind_next = imu_fd_pkg::KIND_ACC;
                        imu_fd_pkg::TYPE_GYRO:  fkind_next = imu_fd_pkg::KIND_GYRO;
                        imu_fd_pkg::TYPE_ANGLE: fkind_next = imu_fd_pkg::KIND_ANGLE;
                        imu_fd_pkg::TYPE_PRESS: fkind_next = imu_fd_pkg::KIND_PRESS;
                        imu_fd_pkg::TYPE_QUAT:  fkind_next = imu_fd_pkg::KIND_QUAT;
                        default: begin
                            phase_next = PH_HUNT;
                            count_next = count_reg;
                        end
                    endcase
                end
                PH_BODY: begin
                    if (!count_reg[3]) begin
                        buf_we     = 1'b1;
                        count_next = count_reg + 4'd1;
                    end else begin
                        // checksum byte closes the frame
                        res_valid       = 1'b1;
                        res.kind        = fkind_reg;
                        res.word0       = {payload_reg[1], payload_reg[0]};
                        res.word1       = {payload_reg[3], payload_reg[2]};
                        res.word2       = {payload_reg[5], payload_reg[4]};
                        res.word3       = {payload_reg[7], payload_reg[6]};
                        if (fkind_reg == imu_fd_pkg::KIND_PRESS) begin
                            res.pressure = {payload_reg[3], payload_reg[2],
                                            payload_reg[1], payload_reg[0]};
                        end
                        res.frame_index = frames_reg;
                        seen_next       = seen_reg | kind_flag;
                        frames_next     = frames_reg + 8'd1;
                        phase_next      = PH_HUNT;
                        count_next      = '0;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            fkind_reg  <= '0;
            seen_reg   <= '0;
            frames_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            fkind_reg  <= fkind_next;
            seen_reg   <= seen_next;
            frames_reg <= frames_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && buf_we) payload_reg[count_reg[2:0]] <= rx_byte;
    end

endmodule

>>> src/imu_frame_deframer.sv
// IMU serial frame deframer: stream in one byte or burst marker per transaction,
// stream out frame and burst summary results.
// Depends on imu_fd_pkg and imu_fd_parser.
//
// Slave channel: s_tdata[7:0] is the received byte, s_tuser is high for an
// end-of-burst marker (the byte is then ignored). Master channel: m_tuser is
// the result kind, m_tdata carries the words, pressure, frame index and the
// set-complete flag. A frame result follows the checksum byte; a burst marker
// always yields a summary. Other bytes yield nothing.
// An accepted transaction is held in an input register, and the parser writes
// its result into the output register, which offers it on m_tvalid.
// Throughput is one transaction per cycle while the output register is free
// or the item yields no result; the parser step between the two registers
// is combinational.
// When m_tready is low with a result held, the input register still drains
// items that produce no result; one that produces a result waits, and
// s_tready drops once the input register is occupied.
// Reset (synchronous, aresetn low) empties both registers, returns the parser
// to header hunting and clears the kind flags and the frame counter.
module imu_frame_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [imu_fd_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    input  logic                                s_tuser,  // [0] action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] word0, [31:16] word1, [47:32] word2, [63:48] word3,
    // [95:64] pressure, [103:96] frame_index, [104] set_complete, rest zero
    output logic [imu_fd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                          m_tuser   // [2:0] kind
);

    logic                in_valid_reg;
    logic                in_action_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg;
    imu_fd_pkg::result_t out_res_reg;

    logic                out_free;
    logic                step;
    logic                res_valid;
    imu_fd_pkg::result_t res;

    assign out_free = !out_valid_reg || m_tready;
    // items without a result never need the output register
    assign step     = in_valid_reg && (out_free || !res_valid);
    assign s_tready = !in_valid_reg || step;

    imu_fd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .action    (in_action_reg),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (step && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata[7:0];
        end
        if (step && res_valid) out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {7'd0,
                       out_res_reg.set_complete,
                       out_res_reg.frame_index,
                       out_res_reg.pressure,
                       out_res_reg.word3,
                       out_res_reg.word2,
                       out_res_reg.word1,
                       out_res_reg.word0};

endmodule
